// ===== design/color_box_threshold_centroid_unit_defines.svh =====
// ----------------------------------------------------------------------------
// color box threshold centroid: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COLOR_BOX_THRESHOLD_CENTROID_UNIT_DEFINES_SVH
`define COLOR_BOX_THRESHOLD_CENTROID_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CBTC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CBTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbtc_pkg
// Widths, limits, register indexes, controller states and the command and
// status bundles of the color box threshold centroid unit.
// ----------------------------------------------------------------------------
package cbtc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int CHAN_W   = 8;
   localparam int COORD_W  = 10;
   localparam int FRAC_W   = 16;
   localparam int COUNT_W  = 21;
   localparam int SUM_W    = 31;
   localparam int PROD_W   = COUNT_W + FRAC_W;
   localparam int STEP_W   = $clog2(SUM_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam longint PIX_PRODUCT = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
   localparam longint COUNT_CAP   = (longint'(1) <<< COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] PIXEL_LIMIT =
      COUNT_W'((PIX_PRODUCT < COUNT_CAP) ? PIX_PRODUCT : COUNT_CAP);

   localparam logic [SUM_W-1:0]   SUM_CAP   = '1;
   localparam logic [COORD_W-1:0] COORD_MAX = '1;
   localparam logic [CHAN_W-1:0]  MASK_ON   = 8'd255;
   localparam logic [CHAN_W-1:0]  MASK_OFF  = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_RED_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HIGH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_HIGH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HIGH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRACTION = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_COMPARE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take;          // accept the pixel and accumulate
      logic emit;          // load a plain result for a pixel that does not close a frame
      logic load_product;  // register fraction times pixel total
      logic compare;       // decide found and start the dividers on a pass
      logic finish;        // load the frame-closing result and clear accumulators
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic pass;
      logic div_done;
   } status_type;

endpackage

// ===== design/color_box_threshold_centroid_unit.sv =====
// ----------------------------------------------------------------------------
// color_box_threshold_centroid_unit
// Color box pixel threshold with per-frame centroid of the matching pixels.
// ----------------------------------------------------------------------------
// A pixel that does not close a frame has its result loaded into the output
// register in the cycle it is accepted, and the next pixel may follow at once
// when that result is taken in the same cycle; a result left waiting holds off
// the next pixel until it is taken. The pixel marked last is followed by the
// threshold product, the compare, then, when the frame qualifies, the
// bit-serial divider that forms the mean column and row (one quotient bit per
// cycle, both coordinates side by side), and last the load of the result,
// which waits while the result register stays full. No new pixel is accepted
// during that time.
// Register writes should be made while no item is in flight.
module color_box_threshold_centroid_unit
   import cbtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [COORD_W-1:0]    req_row,
   input  logic                  req_last_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_W-1:0]     rsp_mask_value,
   output logic                  rsp_frame_end,
   output logic                  rsp_found,
   output logic [COORD_W-1:0]    rsp_center_col,
   output logic [COORD_W-1:0]    rsp_center_row
);

   cmd_type    cmd;
   status_type status;

   cbtc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_pixel (req_last_pixel),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   cbtc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_col          (req_col),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mask_value   (rsp_mask_value),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_found        (rsp_found),
      .rsp_center_col   (rsp_center_col),
      .rsp_center_row   (rsp_center_row)
   );

endmodule

// ===== design/cbtc_divider.sv =====
// ----------------------------------------------------------------------------
// cbtc_divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbtc_divider
   import cbtc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [SUM_W-1:0]   quotient
);

   logic               run_ff, run_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W:0]   shifted;
   logic [COUNT_W:0]   diff;
   logic               fits;
   logic               last_step;

   assign last_step = (step_ff == STEP_W'(SUM_W - 1));
   assign shifted   = {rem_ff[COUNT_W-1:0], quo_ff[SUM_W-1]};
   assign diff      = shifted - {1'b0, divisor};
   assign fits      = (shifted >= {1'b0, divisor});
   assign done      = run_ff && last_step;
   assign quotient  = quo_ff;

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (run_ff) begin
         rem_in  = fits ? diff : shifted;
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== design/cbtc_datapath.sv =====
// ----------------------------------------------------------------------------
// cbtc_datapath
// Color box test, frame accumulators, threshold product and compare, the two
// centroid dividers, held centroid and the result register.
// ----------------------------------------------------------------------------
module cbtc_datapath
   import cbtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [COORD_W-1:0]    req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_W-1:0]     rsp_mask_value,
   output logic                  rsp_frame_end,
   output logic                  rsp_found,
   output logic [COORD_W-1:0]    rsp_center_col,
   output logic [COORD_W-1:0]    rsp_center_row
);

   logic [CHAN_W-1:0]  red_low_ff, red_high_ff, green_low_ff, green_high_ff;
   logic [CHAN_W-1:0]  blue_low_ff, blue_high_ff;
   logic [FRAC_W-1:0]  min_fraction_ff;

   logic [COUNT_W-1:0] match_count_ff, match_count_in;
   logic [COUNT_W-1:0] frame_pixels_ff, frame_pixels_in;
   logic [SUM_W-1:0]   col_sum_ff, col_sum_in;
   logic [SUM_W-1:0]   row_sum_ff, row_sum_in;
   logic [COORD_W-1:0] held_col_ff, held_col_in;
   logic [COORD_W-1:0] held_row_ff, held_row_in;
   logic [PROD_W-1:0]  product_ff;
   logic               found_ff;
   logic               mask_hit_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_mask_ff;
   logic               rsp_frame_end_ff, rsp_found_ff;
   logic [COORD_W-1:0] rsp_col_ff, rsp_row_ff;

   logic               hit;
   logic [SUM_W:0]     col_add, row_add;
   logic               pass;
   logic               col_done, row_done;
   logic [SUM_W-1:0]   col_quo, row_quo;
   logic [COORD_W-1:0] col_mean, row_mean;

   assign hit = (req_red   >= red_low_ff)   && (req_red   <= red_high_ff)   &&
                (req_green >= green_low_ff) && (req_green <= green_high_ff) &&
                (req_blue  >= blue_low_ff)  && (req_blue  <= blue_high_ff);

   // sums stay at or below the cap, so one carry bit shows the overflow
   assign col_add = {1'b0, col_sum_ff} + (SUM_W+1)'(req_col);
   assign row_add = {1'b0, row_sum_ff} + (SUM_W+1)'(req_row);

   assign pass = ({match_count_ff, {FRAC_W{1'b0}}} > product_ff) &&
                 (match_count_ff != '0);

   assign col_mean = (|col_quo[SUM_W-1:COORD_W]) ? COORD_MAX : col_quo[COORD_W-1:0];
   assign row_mean = (|row_quo[SUM_W-1:COORD_W]) ? COORD_MAX : row_quo[COORD_W-1:0];

   cbtc_divider u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.compare && pass),
      .dividend (col_sum_ff),
      .divisor  (match_count_ff),
      .done     (col_done),
      .quotient (col_quo)
   );

   cbtc_divider u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.compare && pass),
      .dividend (row_sum_ff),
      .divisor  (match_count_ff),
      .done     (row_done),
      .quotient (row_quo)
   );

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.pass     = pass;
   assign status.div_done = col_done && row_done;

   always_comb begin
      match_count_in  = match_count_ff;
      frame_pixels_in = frame_pixels_ff;
      col_sum_in      = col_sum_ff;
      row_sum_in      = row_sum_ff;
      held_col_in     = held_col_ff;
      held_row_in     = held_row_ff;
      if (cmd.take) begin
         if (frame_pixels_ff != PIXEL_LIMIT) begin
            frame_pixels_in = frame_pixels_ff + 1'b1;
         end
         if (hit) begin
            if (match_count_ff != PIXEL_LIMIT) begin
               match_count_in = match_count_ff + 1'b1;
            end
            col_sum_in = col_add[SUM_W] ? SUM_CAP : col_add[SUM_W-1:0];
            row_sum_in = row_add[SUM_W] ? SUM_CAP : row_add[SUM_W-1:0];
         end
      end else if (cmd.finish) begin
         match_count_in  = '0;
         frame_pixels_in = '0;
         col_sum_in      = '0;
         row_sum_in      = '0;
         if (found_ff) begin
            held_col_in = col_mean;
            held_row_in = row_mean;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit || cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_low_ff      <= '0;
         red_high_ff     <= '1;
         green_low_ff    <= '0;
         green_high_ff   <= '1;
         blue_low_ff     <= '0;
         blue_high_ff    <= '1;
         min_fraction_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RED_LOW:      red_low_ff      <= csr_write_data[CHAN_W-1:0];
            CSR_RED_HIGH:     red_high_ff     <= csr_write_data[CHAN_W-1:0];
            CSR_GREEN_LOW:    green_low_ff    <= csr_write_data[CHAN_W-1:0];
            CSR_GREEN_HIGH:   green_high_ff   <= csr_write_data[CHAN_W-1:0];
            CSR_BLUE_LOW:     blue_low_ff     <= csr_write_data[CHAN_W-1:0];
            CSR_BLUE_HIGH:    blue_high_ff    <= csr_write_data[CHAN_W-1:0];
            CSR_MIN_FRACTION: min_fraction_ff <= csr_write_data[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_count_ff  <= '0;
         frame_pixels_ff <= '0;
         col_sum_ff      <= '0;
         row_sum_ff      <= '0;
         held_col_ff     <= '0;
         held_row_ff     <= '0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         match_count_ff  <= match_count_in;
         frame_pixels_ff <= frame_pixels_in;
         col_sum_ff      <= col_sum_in;
         row_sum_ff      <= row_sum_in;
         held_col_ff     <= held_col_in;
         held_row_ff     <= held_row_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (cmd.compare) begin
            found_ff <= pass;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mask_hit_ff <= hit;
      end
      if (cmd.load_product) begin
         product_ff <= PROD_W'(min_fraction_ff) * PROD_W'(frame_pixels_ff);
      end
      if (cmd.emit) begin
         rsp_mask_ff      <= hit ? MASK_ON : MASK_OFF;
         rsp_frame_end_ff <= 1'b0;
         rsp_found_ff     <= 1'b0;
         rsp_col_ff       <= held_col_ff;
         rsp_row_ff       <= held_row_ff;
      end else if (cmd.finish) begin
         rsp_mask_ff      <= mask_hit_ff ? MASK_ON : MASK_OFF;
         rsp_frame_end_ff <= 1'b1;
         rsp_found_ff     <= found_ff;
         rsp_col_ff       <= held_col_in;
         rsp_row_ff       <= held_row_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mask_value = rsp_mask_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_center_row = rsp_row_ff;

endmodule

// ===== design/cbtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbtc_ctrl
// Sequencer: pixel intake, and the compare and divide steps that close a
// frame.
// ----------------------------------------------------------------------------
module cbtc_ctrl
   import cbtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_pixel,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               cmd.take = 1'b1;
               if (req_last_pixel) begin
                  state_in = ST_MULT;
               end else begin
                  cmd.emit = 1'b1;
               end
            end
         end
         ST_MULT: begin
            cmd.load_product = 1'b1;
            state_in         = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = status.pass ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for room in the result register
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/cbtc_checker.sv =====
// ----------------------------------------------------------------------------
// cbtc_checker
// Port-level checks of the color box threshold centroid unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "color_box_threshold_centroid_unit_defines.svh"

module cbtc_checker
   import cbtc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_pixel,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CHAN_W-1:0]     rsp_mask_value,
   input logic                  rsp_frame_end,
   input logic                  rsp_found,
   input logic [COORD_W-1:0]    rsp_center_col,
   input logic [COORD_W-1:0]    rsp_center_row
);

   // a stalled result holds its value
   `CBTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mask_value) && $stable(rsp_found) && $stable(rsp_center_col) && $stable(rsp_center_row), "stalled result changed")

   `CBTC_ASSERT_SAME(a_mask_code, rsp_valid, rsp_mask_value == MASK_ON || rsp_mask_value == MASK_OFF, "mask is neither on nor off")

   `CBTC_ASSERT_SAME(a_found_at_end, rsp_valid && rsp_found, rsp_frame_end, "found outside a frame end")

   // closing a frame blocks intake while the centroid is worked out
   `CBTC_ASSERT_NEXT(a_close_blocks, req_valid && req_ready && req_last_pixel, !req_ready, "intake open right after a frame end")

endmodule

bind color_box_threshold_centroid_unit cbtc_checker u_cbtc_checker (.*);
